// File: rtl/mi4_pkg.sv
// Shared constants, types and index functions for the 4x4 matrix inverse core.
`timescale 1ns / 1ps

package mi4_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int NELEM     = 16;
  localparam int ADDR_W    = 4;
  localparam int TERMS     = 6;
  localparam int TERM_W    = 3;
  localparam int ADJ_W     = 97;
  localparam int DET_W     = 130;
  localparam int REM_W     = DET_W + ELEM_W;
  localparam int QCNT_W    = 5;

  localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(TERMS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NELEM - 1);
  localparam logic [ELEM_W-1:0] Q_MIN     = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic [ELEM_W-1:0] Q_MAX     = {1'b0, {(ELEM_W-1){1'b1}}};

  typedef struct packed {
    logic             done;
    logic [DET_W-1:0] det;
  } eng_status_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [ELEM_W-1:0] quo;
  } div_result_t;

  // Column of the three-by-three minor that factor k of a determinant term uses.
  function automatic logic [1:0] perm_col(input logic [TERM_W-1:0] term, input logic [1:0] k);
    logic [5:0] cols;
    unique case (term)
      3'd0:    cols = {2'd2, 2'd1, 2'd0};
      3'd1:    cols = {2'd0, 2'd2, 2'd1};
      3'd2:    cols = {2'd1, 2'd0, 2'd2};
      3'd3:    cols = {2'd1, 2'd2, 2'd0};
      3'd4:    cols = {2'd2, 2'd0, 2'd1};
      3'd5:    cols = {2'd0, 2'd1, 2'd2};
      default: cols = '0;
    endcase
    return cols[{k, 1'b0} +: 2];
  endfunction

  // Matrix address of factor k of a term of the cofactor that lands at adjugate entry idx.
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [ADDR_W-1:0] idx,
                                                  input logic [TERM_W-1:0] term,
                                                  input logic [1:0] k);
    logic [1:0] p;
    logic [1:0] q;
    logic [1:0] s;
    logic [1:0] row;
    logic [1:0] col;
    p   = idx[1:0];
    q   = idx[3:2];
    s   = perm_col(term, k);
    row = (k < p) ? k : k + 2'd1;
    col = (s < q) ? s : s + 2'd1;
    return {row, col};
  endfunction

  // True where the term enters the adjugate entry with a minus sign.
  function automatic logic term_neg(input logic [ADDR_W-1:0] idx, input logic [TERM_W-1:0] term);
    return (term >= 3'd3) ^ idx[0] ^ idx[2];
  endfunction

endpackage

// File: rtl/mi4_adj_engine.sv
// Matrix and adjugate memories with the cofactor and determinant sequencer.
`timescale 1ns / 1ps

module mi4_adj_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        elem_accept,
  input  logic [mi4_pkg::ELEM_W-1:0]  elem_data,
  output logic                        load_open,
  input  logic [mi4_pkg::ADDR_W-1:0]  adj_rd_addr,
  output logic [mi4_pkg::ADJ_W-1:0]   adj_rd_data,
  output mi4_pkg::eng_status_t        status
);

  typedef enum logic [3:0] {
    S_LOAD, S_RD0, S_RD1, S_RD2, S_M0, S_M1, S_M2, S_ACC, S_WR,
    S_DRD, S_DM0, S_DM1, S_DM2, S_DM3, S_DACC
  } state_t;

  state_t                              state_r;
  logic [mi4_pkg::ADDR_W-1:0]          load_cnt_r;
  logic [mi4_pkg::ADDR_W-1:0]          idx_r;
  logic [mi4_pkg::TERM_W-1:0]          term_r;
  logic                                done_r;
  logic signed [mi4_pkg::ELEM_W-1:0]   op0_r;
  logic signed [mi4_pkg::ELEM_W-1:0]   op1_r;
  logic signed [mi4_pkg::ELEM_W-1:0]   op2_r;
  logic signed [2*mi4_pkg::ELEM_W-1:0] prod_r;
  logic signed [2*mi4_pkg::ELEM_W:0]   plo_r;
  logic signed [2*mi4_pkg::ELEM_W-1:0] phi_r;
  logic signed [mi4_pkg::ADJ_W-1:0]    acc_r;
  logic signed [mi4_pkg::DET_W-1:0]    det_r;
  logic signed [2*mi4_pkg::ELEM_W:0]   dp0_r;
  logic signed [2*mi4_pkg::ELEM_W:0]   dp1_r;
  logic signed [2*mi4_pkg::ELEM_W:0]   dp2_r;
  logic signed [mi4_pkg::ADJ_W-1:0]    trip;
  logic signed [mi4_pkg::DET_W-1:0]    det_nxt;
  logic [mi4_pkg::ADDR_W-1:0]          mat_rd_addr;
  logic [mi4_pkg::ELEM_W-1:0]          mat_rd_r;
  logic [mi4_pkg::ADJ_W-1:0]           adj_rd_r;

  logic [mi4_pkg::ELEM_W-1:0] mat_mem [mi4_pkg::NELEM];
  logic [mi4_pkg::ADJ_W-1:0]  adj_mem [mi4_pkg::NELEM];

  always_comb begin
    unique case (state_r)
      S_RD0:   mat_rd_addr = mi4_pkg::elem_addr(idx_r, term_r, 2'd0);
      S_RD1:   mat_rd_addr = mi4_pkg::elem_addr(idx_r, term_r, 2'd1);
      S_RD2:   mat_rd_addr = mi4_pkg::elem_addr(idx_r, term_r, 2'd2);
      S_DRD:   mat_rd_addr = {2'b00, idx_r[3:2]};
      default: mat_rd_addr = '0;
    endcase
  end

  assign trip = (mi4_pkg::ADJ_W'(phi_r) << mi4_pkg::ELEM_W) + mi4_pkg::ADJ_W'(plo_r);
  assign det_nxt = det_r + mi4_pkg::DET_W'(dp0_r)
                 + (mi4_pkg::DET_W'(dp1_r) << mi4_pkg::ELEM_W)
                 + (mi4_pkg::DET_W'(dp2_r) << (2*mi4_pkg::ELEM_W));

  always_ff @(posedge clk) begin
    if (elem_accept) begin
      mat_mem[load_cnt_r] <= elem_data;
    end
    mat_rd_r <= mat_mem[mat_rd_addr];
    if (state_r == S_WR) begin
      adj_mem[idx_r] <= acc_r;
    end
    adj_rd_r <= adj_mem[adj_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      load_cnt_r <= '0;
      idx_r      <= '0;
      term_r     <= '0;
      done_r     <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (elem_accept) begin
            load_cnt_r <= load_cnt_r + 1'b1;
            if (load_cnt_r == mi4_pkg::LAST_ADDR) begin
              idx_r   <= '0;
              term_r  <= '0;
              acc_r   <= '0;
              det_r   <= '0;
              state_r <= S_RD0;
            end
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          op0_r   <= mat_rd_r;
          state_r <= S_RD2;
        end
        S_RD2: begin
          op1_r   <= mat_rd_r;
          state_r <= S_M0;
        end
        S_M0: begin
          op2_r   <= mat_rd_r;
          prod_r  <= op0_r * op1_r;
          state_r <= S_M1;
        end
        S_M1: begin
          plo_r   <= $signed({1'b0, prod_r[mi4_pkg::ELEM_W-1:0]}) * op2_r;
          state_r <= S_M2;
        end
        S_M2: begin
          phi_r   <= $signed(prod_r[2*mi4_pkg::ELEM_W-1:mi4_pkg::ELEM_W]) * op2_r;
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= mi4_pkg::term_neg(idx_r, term_r) ? acc_r - trip : acc_r + trip;
          if (term_r == mi4_pkg::LAST_TERM) begin
            state_r <= S_WR;
          end else begin
            term_r  <= term_r + 1'b1;
            state_r <= S_RD0;
          end
        end
        S_WR, S_DACC: begin
          if (state_r == S_DACC) begin
            det_r <= det_nxt;
          end
          if (state_r == S_WR && idx_r[1:0] == 2'd0) begin
            state_r <= S_DRD;
          end else if (idx_r == mi4_pkg::LAST_ADDR) begin
            done_r  <= 1'b1;
            state_r <= S_LOAD;
          end else begin
            idx_r   <= idx_r + 1'b1;
            term_r  <= '0;
            acc_r   <= '0;
            state_r <= S_RD0;
          end
        end
        S_DRD: state_r <= S_DM0;
        S_DM0: begin
          op0_r   <= mat_rd_r;
          state_r <= S_DM1;
        end
        S_DM1: begin
          dp0_r   <= $signed({1'b0, acc_r[mi4_pkg::ELEM_W-1:0]}) * op0_r;
          state_r <= S_DM2;
        end
        S_DM2: begin
          dp1_r   <= $signed({1'b0, acc_r[2*mi4_pkg::ELEM_W-1:mi4_pkg::ELEM_W]}) * op0_r;
          state_r <= S_DM3;
        end
        S_DM3: begin
          dp2_r   <= $signed(acc_r[mi4_pkg::ADJ_W-1:2*mi4_pkg::ELEM_W]) * op0_r;
          state_r <= S_DACC;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign load_open   = (state_r == S_LOAD);
  assign adj_rd_data = adj_rd_r;
  assign status.done = done_r;
  assign status.det  = det_r;

endmodule

// File: rtl/mi4_divider.sv
// Restoring divider that forms one saturated fixed-point quotient a bit per cycle.
`timescale 1ns / 1ps

module mi4_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [mi4_pkg::ADJ_W-1:0]  num,
  input  logic signed [mi4_pkg::DET_W-1:0]  den,
  output mi4_pkg::div_result_t              result
);

  typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_FIN} state_t;

  state_t                      state_r;
  logic                        done_r;
  logic                        neg_r;
  logic                        ovf_r;
  logic                        sat_r;
  logic [mi4_pkg::QCNT_W-1:0]  cnt_r;
  logic [mi4_pkg::REM_W-1:0]   rem_r;
  logic [mi4_pkg::REM_W-1:0]   dsh_r;
  logic [mi4_pkg::DET_W-1:0]   dmag_r;
  logic [mi4_pkg::ELEM_W-1:0]  q_r;
  logic [mi4_pkg::ELEM_W-1:0]  quo_r;
  logic [mi4_pkg::ADJ_W-1:0]   nmag;
  logic                        ge;

  assign nmag = num[mi4_pkg::ADJ_W-1] ? mi4_pkg::ADJ_W'(-num) : mi4_pkg::ADJ_W'(num);
  assign ge   = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            rem_r   <= mi4_pkg::REM_W'(nmag) << (2*mi4_pkg::FRAC_BITS);
            dmag_r  <= den[mi4_pkg::DET_W-1] ? mi4_pkg::DET_W'(-den) : mi4_pkg::DET_W'(den);
            neg_r   <= num[mi4_pkg::ADJ_W-1] ^ den[mi4_pkg::DET_W-1];
            state_r <= D_CHK;
          end
        end
        D_CHK: begin
          ovf_r   <= (rem_r >= {dmag_r, {mi4_pkg::ELEM_W{1'b0}}});
          dsh_r   <= mi4_pkg::REM_W'(dmag_r) << (mi4_pkg::ELEM_W-1);
          cnt_r   <= '1;
          q_r     <= '0;
          state_r <= D_RUN;
        end
        D_RUN: begin
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          q_r   <= {q_r[mi4_pkg::ELEM_W-2:0], ge};
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0 || ovf_r) begin
            state_r <= D_FIN;
          end
        end
        D_FIN: begin
          done_r  <= 1'b1;
          state_r <= D_IDLE;
          priority if (ovf_r) begin
            sat_r <= 1'b1;
            quo_r <= neg_r ? mi4_pkg::Q_MIN : mi4_pkg::Q_MAX;
          end else if (neg_r) begin
            sat_r <= (q_r > mi4_pkg::Q_MIN);
            quo_r <= (q_r > mi4_pkg::Q_MIN) ? mi4_pkg::Q_MIN : -q_r;
          end else begin
            sat_r <= (q_r > mi4_pkg::Q_MAX);
            quo_r <= (q_r > mi4_pkg::Q_MAX) ? mi4_pkg::Q_MAX : q_r;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign result.done = done_r;
  assign result.sat  = sat_r;
  assign result.quo  = quo_r;

endmodule

// File: rtl/matrix_inverse_4x4_core.sv
// Top level of the 4x4 fixed-point matrix inverse core.
// Sixteen signed Q16.16 elements are taken as requests in row-major order, one per cycle
// while in_stall is low. The core then forms every signed 3x3 minor of the adjugate and the
// exact determinant, and emits sixteen row-major results, each the adjugate entry divided
// by the determinant, truncated toward zero and saturated, from a divider that settles one
// quotient bit per cycle; a singular matrix skips the division and finishes sooner. No new
// matrix is taken until the last result of the previous one has been placed in the output
// register.
`timescale 1ns / 1ps

module matrix_inverse_4x4_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mi4_pkg::ELEM_W-1:0] in_element,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mi4_pkg::ELEM_W-1:0] out_inv_element,
  output logic                              out_singular,
  output logic                              out_saturated,
  output logic                              out_last
);

  typedef enum logic [2:0] {O_IDLE, O_RD, O_LD, O_DIV, O_OUT} state_t;

  state_t                      state_r;
  logic [mi4_pkg::ADDR_W-1:0]  k_r;
  logic                        sing_r;
  logic [mi4_pkg::ELEM_W-1:0]  res_q_r;
  logic                        res_sat_r;
  logic                        out_valid_r;
  logic [mi4_pkg::ELEM_W-1:0]  out_q_r;
  logic                        out_sing_r;
  logic                        out_sat_r;
  logic                        out_last_r;
  logic                        load_open;
  logic                        in_accept;
  logic                        out_load;
  logic                        div_start;
  logic [mi4_pkg::ADJ_W-1:0]   adj_rd_data;
  mi4_pkg::eng_status_t        status;
  mi4_pkg::div_result_t        div_res;

  assign in_stall  = !load_open || (state_r != O_IDLE) || status.done;
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == O_OUT) && (!out_valid_r || !out_stall);
  assign div_start = (state_r == O_LD) && !sing_r;

  mi4_adj_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .elem_accept (in_accept),
    .elem_data   (in_element),
    .load_open   (load_open),
    .adj_rd_addr (k_r),
    .adj_rd_data (adj_rd_data),
    .status      (status)
  );

  mi4_divider u_divider (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    ($signed(adj_rd_data)),
    .den    ($signed(status.det)),
    .result (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= O_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_q_r     <= res_q_r;
        out_sing_r  <= sing_r;
        out_sat_r   <= res_sat_r;
        out_last_r  <= (k_r == mi4_pkg::LAST_ADDR);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        O_IDLE: begin
          if (status.done) begin
            sing_r  <= (status.det == '0);
            k_r     <= '0;
            state_r <= O_RD;
          end
        end
        O_RD: state_r <= O_LD;
        O_LD: begin
          if (sing_r) begin
            res_q_r   <= '0;
            res_sat_r <= 1'b0;
            state_r   <= O_OUT;
          end else begin
            state_r <= O_DIV;
          end
        end
        O_DIV: begin
          if (div_res.done) begin
            res_q_r   <= div_res.quo;
            res_sat_r <= div_res.sat;
            state_r   <= O_OUT;
          end
        end
        O_OUT: begin
          if (out_load) begin
            if (k_r == mi4_pkg::LAST_ADDR) begin
              state_r <= O_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= O_RD;
            end
          end
        end
        default: state_r <= O_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_inv_element = $signed(out_q_r);
  assign out_singular    = out_sing_r;
  assign out_saturated   = out_sat_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_inv_element == '0 && !out_saturated)
    else $error("singular result carries a nonzero element or a saturation flag");

  a_sat_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_inv_element == $signed(mi4_pkg::Q_MAX) || out_inv_element == $signed(mi4_pkg::Q_MIN))
    else $error("saturated result is not at a range limit");

  a_engine_idle_drain: assert property (@(posedge clk) disable iff (!rst_n)
    status.done |-> state_r == O_IDLE)
    else $error("new adjugate finished while results of the previous matrix were pending");

  a_div_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == O_DIV)
    else $error("divider finished outside the divide phase");
`endif

endmodule
